[src/plgs_pkg.sv]
`timescale 1ns / 1ps

package plgs_pkg;

	localparam int unsigned PIX_W       = 8;
	localparam int unsigned NUM_W       = 2 * PIX_W;
	localparam int unsigned RECIP_SHIFT = NUM_W;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

	// register indexes on the write port
	localparam logic [1:0] REG_BREAK1_IN  = 2'd0;
	localparam logic [1:0] REG_BREAK1_OUT = 2'd1;
	localparam logic [1:0] REG_BREAK2_IN  = 2'd2;
	localparam logic [1:0] REG_BREAK2_OUT = 2'd3;

	localparam logic [PIX_W-1:0] RST_BREAK1_IN  = 8'd50;
	localparam logic [PIX_W-1:0] RST_BREAK1_OUT = 8'd50;
	localparam logic [PIX_W-1:0] RST_BREAK2_IN  = 8'd200;
	localparam logic [PIX_W-1:0] RST_BREAK2_OUT = 8'd200;

	// curve breakpoints as seen by the classifier
	typedef struct packed {
		logic [PIX_W-1:0] x1;
		logic [PIX_W-1:0] y1;
		logic [PIX_W-1:0] x2;
		logic [PIX_W-1:0] y2;
	} curve_t;

	// one classified pixel: result = base +/- num / den
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [PIX_W-1:0] den;
		logic             neg;
		logic [PIX_W-1:0] base;
		logic             last;
	} item_t;

endpackage

[src/plgs_front.sv]
`timescale 1ns / 1ps

module plgs_front (
	input  plgs_pkg::curve_t              curve,
	input  logic [plgs_pkg::PIX_W-1:0]    pixel,
	input  logic                          last,
	output plgs_pkg::item_t               item
);

	logic                       seg1;
	logic                       seg2;
	logic [plgs_pkg::PIX_W-1:0] slope;
	logic [plgs_pkg::PIX_W-1:0] dx;
	logic [plgs_pkg::PIX_W-1:0] den;
	logic [plgs_pkg::PIX_W-1:0] base;
	logic                       neg;

	assign seg1 = (pixel <= curve.x1);
	assign seg2 = !seg1 && (pixel <= curve.x2);

	always_comb begin
		if (seg1) begin
			slope = curve.y1;
			dx    = pixel;
			den   = curve.x1;
			base  = '0;
			neg   = 1'b0;
		end else if (seg2) begin
			neg   = (curve.y2 < curve.y1);
			slope = neg ? (curve.y1 - curve.y2) : (curve.y2 - curve.y1);
			dx    = pixel - curve.x1;
			den   = curve.x2 - curve.x1;
			base  = curve.y1;
		end else begin
			slope = plgs_pkg::FULL_SCALE - curve.y2;
			dx    = pixel - curve.x2;
			den   = plgs_pkg::FULL_SCALE - curve.x2;
			base  = curve.y2;
			neg   = 1'b0;
		end
	end

	// a zero span only shows up with a zero numerator
	always_comb begin
		item.num  = {{plgs_pkg::PIX_W{1'b0}}, slope} * {{plgs_pkg::PIX_W{1'b0}}, dx};
		item.den  = (den == '0) ? plgs_pkg::PIX_W'(1) : den;
		item.neg  = neg;
		item.base = base;
		item.last = last;
	end

endmodule

[src/plgs_queue.sv]
`timescale 1ns / 1ps

module plgs_queue #(
	parameter int unsigned DEPTH = plgs_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  plgs_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output plgs_pkg::item_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	plgs_pkg::item_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/plgs_back.sv]
`timescale 1ns / 1ps

module plgs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  plgs_pkg::item_t            item,
	output logic                       done,
	output logic [plgs_pkg::PIX_W-1:0] pixel_out,
	output logic                       last_out
);

	localparam int unsigned NW = plgs_pkg::NUM_W;
	localparam int unsigned PW = plgs_pkg::PIX_W;
	localparam int unsigned RW = plgs_pkg::RECIP_W;
	localparam int unsigned PRODUCT_W = NW + RW;
	localparam int unsigned SUM_W = NW + 2;

	// floor(2^16 / d) for every divisor
	logic [RW-1:0] recip_tab [2**PW];

	for (genvar g = 0; g < 2**PW; g++) begin : g_recip
		localparam int unsigned RV = (1 << plgs_pkg::RECIP_SHIFT) / ((g == 0) ? 1 : g);
		assign recip_tab[g] = RW'(RV);
	end

	logic [PRODUCT_W-1:0] product;
	logic [NW-1:0]        prod_s1;
	logic [NW-1:0]        num_s1;
	logic [PW-1:0]        den_s1;
	logic                 neg_s1;
	logic [PW-1:0]        base_s1;
	logic                 last_s1;
	logic                 valid_s1;

	logic [NW-1:0]        q_est;
	logic [NW+PW-1:0]     q_den;
	logic [NW+PW-1:0]     rem;
	logic [NW-1:0]        q_s2;
	logic                 neg_s2;
	logic [PW-1:0]        base_s2;
	logic                 last_s2;
	logic                 valid_s2;

	logic signed [SUM_W-1:0] sum;

	// stage 1: quotient estimate through the reciprocal
	assign product = {{RW{1'b0}}, item.num} * {{NW{1'b0}}, recip_tab[item.den]};

	always_ff @(posedge clk) begin
		prod_s1 <= product[plgs_pkg::RECIP_SHIFT +: NW];
		num_s1  <= item.num;
		den_s1  <= item.den;
		neg_s1  <= item.neg;
		base_s1 <= item.base;
		last_s1 <= item.last;
	end

	// stage 2: estimate is low by at most one
	assign q_est = prod_s1;
	assign q_den = {{PW{1'b0}}, q_est} * {{NW{1'b0}}, den_s1};
	assign rem   = {{PW{1'b0}}, num_s1} - q_den;

	always_ff @(posedge clk) begin
		q_s2    <= (rem >= {{NW{1'b0}}, den_s1}) ? q_est + 1'b1 : q_est;
		neg_s2  <= neg_s1;
		base_s2 <= base_s1;
		last_s2 <= last_s1;
	end

	// stage 3: add to or subtract from segment base, clamp to 0..255
	assign sum = neg_s2 ?
		$signed({{(SUM_W-PW){1'b0}}, base_s2}) - $signed({2'b00, q_s2}) :
		$signed({{(SUM_W-PW){1'b0}}, base_s2}) + $signed({2'b00, q_s2});

	always_ff @(posedge clk) begin
		if (sum < 0) begin
			pixel_out <= '0;
		end else if (sum > $signed({{(SUM_W-PW){1'b0}}, plgs_pkg::FULL_SCALE})) begin
			pixel_out <= plgs_pkg::FULL_SCALE;
		end else begin
			pixel_out <= sum[PW-1:0];
		end
		last_out <= last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

endmodule

[src/piecewise_linear_gray_stretch_top.sv]
`timescale 1ns / 1ps

// channel   ports                         moves a word when
// -------   ---------------------------   ------------------------------
// input     start busy pixel_in last_in   start high and busy low at clk
// result    done pixel_out last_out       done high (one cycle, no stall)
// config    wr_en wr_index wr_data        wr_en high at clk
//
// one word per clock sustained while busy is low; each result goes through the queue
// slot and the three-stage back pipeline (reciprocal multiply, remainder correction,
// base add and clamp) before it is on the ports
// arst_n clears the queue and stage valids; breakpoints return to 50/50, 200/200
// busy rises only when the queue is full; the back end drains one word a cycle

module piecewise_linear_gray_stretch_top #(
	parameter int unsigned QUEUE_DEPTH = plgs_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// pixel input
	input  logic                       start,
	output logic                       busy,
	input  logic [plgs_pkg::PIX_W-1:0] pixel_in,
	input  logic                       last_in,
	// pixel result
	output logic                       done,
	output logic [plgs_pkg::PIX_W-1:0] pixel_out,
	output logic                       last_out,
	// breakpoint registers
	input  logic                       wr_en,
	input  logic [1:0]                 wr_index,
	input  logic [plgs_pkg::PIX_W-1:0] wr_data
);

	plgs_pkg::curve_t curve_q;
	plgs_pkg::item_t  front_item;
	plgs_pkg::item_t  head_item;
	logic             queue_full;
	logic             queue_valid;

	// breakpoint registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q.x1 <= plgs_pkg::RST_BREAK1_IN;
			curve_q.y1 <= plgs_pkg::RST_BREAK1_OUT;
			curve_q.x2 <= plgs_pkg::RST_BREAK2_IN;
			curve_q.y2 <= plgs_pkg::RST_BREAK2_OUT;
		end else if (wr_en) begin
			case (wr_index)
				plgs_pkg::REG_BREAK1_IN:  curve_q.x1 <= wr_data;
				plgs_pkg::REG_BREAK1_OUT: curve_q.y1 <= wr_data;
				plgs_pkg::REG_BREAK2_IN:  curve_q.x2 <= wr_data;
				plgs_pkg::REG_BREAK2_OUT: curve_q.y2 <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = queue_full;

	// front: pick the segment and form numerator, divisor and base
	plgs_front u_front (
		.curve (curve_q),
		.pixel (pixel_in),
		.last  (last_in),
		.item  (front_item)
	);

	// short queue between classifier and divide pipeline
	plgs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start),
		.push_item (front_item),
		.pop       (queue_valid),
		.full      (queue_full),
		.not_empty (queue_valid),
		.head      (head_item)
	);

	// back: divide by the segment span and clamp
	plgs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (queue_valid),
		.item      (head_item),
		.done      (done),
		.pixel_out (pixel_out),
		.last_out  (last_out)
	);

endmodule

[src/plgs_checker.sv]
`timescale 1ns / 1ps

module plgs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       last_in,
	input logic                       done,
	input logic                       last_out
);

	logic accepted;

	assign accepted = start && !busy;

	// every accepted word gives a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accepted |-> ##4 done)
		else $error("accepted word produced no result");

	// no result without an accepted word before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accepted, 4))
		else $error("result without matching word");

	// last flag rides along with its pixel
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_in, 4)))
		else $error("last flag out of step");

	// back end drains each cycle, so the queue never fills
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("input stalled");

endmodule

bind piecewise_linear_gray_stretch_top plgs_checker u_plgs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.last_in  (last_in),
	.done     (done),
	.last_out (last_out)
);
